FILE: hw/rtl/pipcp_pkg.sv
`timescale 1ns / 1ps

package pipcp_pkg;

    // Input command codes.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_POS_X        = 2'd0;
    localparam logic [1:0] REG_POS_Y        = 2'd1;
    localparam logic [1:0] REG_ORIENTATION  = 2'd2;
    localparam logic [1:0] REG_VERTEX_COUNT = 2'd3;
    localparam int         CFG_INDEX_W      = 2;
    localparam int         VCOUNT_W         = 5;
    localparam int         VINDEX_W         = 4;

    // Rotation unit: sixteen steps on Q1.30 values held with two guard bits.
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = 4;
    localparam int CS_W         = 34;
    localparam logic signed [CS_W-1:0] CORDIC_START = 34'sd652032874;

    // Arctangent of 2^-i, 2^32 units per turn.
    function automatic logic signed [CS_W-1:0] atan_step(input logic [STEP_W-1:0] i);
        logic signed [CS_W-1:0] v;
        unique case (i)
            4'd0:    v = 34'sh020000000;
            4'd1:    v = 34'sh012E4051E;
            4'd2:    v = 34'sh009FB385B;
            4'd3:    v = 34'sh0051111D4;
            4'd4:    v = 34'sh0028B0D43;
            4'd5:    v = 34'sh00145D7E1;
            4'd6:    v = 34'sh000A2F61E;
            4'd7:    v = 34'sh000517C55;
            4'd8:    v = 34'sh00028BE53;
            4'd9:    v = 34'sh000145F2F;
            4'd10:   v = 34'sh0000A2F98;
            4'd11:   v = 34'sh0000517CC;
            4'd12:   v = 34'sh000028BE6;
            4'd13:   v = 34'sh0000145F3;
            4'd14:   v = 34'sh00000A2FA;
            default: v = 34'sh00000517D;
        endcase
        return v;
    endfunction

    typedef enum logic [3:0] {
        S_IDLE,
        S_CORDIC,
        S_CFIX,
        S_ROT1,
        S_ROT2,
        S_ROT3,
        S_V0,
        S_LOAD,
        S_MUL,
        S_CMP,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load_vertex;
        logic start_query;
        logic cordic_step;
        logic cordic_fix;
        logic rot1;
        logic rot2;
        logic rot3;
        logic v0_cap;
        logic load_cur;
        logic edge_mul;
        logic set_result;
        logic result_val;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic cordic_last;
        logic edge_pos;
        logic edge_last;
        logic out_busy;
    } t_dp_stat;

endpackage

FILE: hw/rtl/pipcp_ctrl.sv
`timescale 1ns / 1ps

module pipcp_ctrl
    import pipcp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_command,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_command == CMD_QUERY) begin
                        o_cmd.start_query = 1'b1;
                        n_state = S_CORDIC;
                    end else begin
                        o_cmd.load_vertex = 1'b1;
                    end
                end
            end
            S_CORDIC: begin
                o_cmd.cordic_step = 1'b1;
                if (i_stat.cordic_last) begin
                    n_state = S_CFIX;
                end
            end
            S_CFIX: begin
                o_cmd.cordic_fix = 1'b1;
                n_state = S_ROT1;
            end
            S_ROT1: begin
                o_cmd.rot1 = 1'b1;
                n_state = S_ROT2;
            end
            S_ROT2: begin
                o_cmd.rot2 = 1'b1;
                n_state = S_ROT3;
            end
            S_ROT3: begin
                o_cmd.rot3 = 1'b1;
                n_state = S_V0;
            end
            S_V0: begin
                o_cmd.v0_cap = 1'b1;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load_cur = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.edge_mul = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                priority if (!i_stat.edge_pos) begin
                    o_cmd.set_result = 1'b1;
                    o_cmd.result_val = 1'b0;
                    n_state = S_OUT;
                end else if (i_stat.edge_last) begin
                    o_cmd.set_result = 1'b1;
                    o_cmd.result_val = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_state = S_LOAD;
                end
            end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

FILE: hw/rtl/pipcp_dp.sv
`timescale 1ns / 1ps

module pipcp_dp
    import pipcp_pkg::*;
#(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_WIDTH  = 32,
    parameter int ANGLE_WIDTH  = 16,
    parameter int CFG_W        = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    output t_dp_stat                      o_stat,
    input  logic                          i_cfg_valid,
    input  logic [CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]              i_cfg_data,
    input  logic [VINDEX_W-1:0]           i_vertex_index,
    input  logic signed [COORD_WIDTH-1:0] i_coord_x,
    input  logic signed [COORD_WIDTH-1:0] i_coord_y,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic                          o_inside_res
);

    localparam int AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int KW  = $clog2(MAX_VERTICES + 1);
    localparam int DW  = COORD_WIDTH + 1;
    localparam int PW  = CS_W + DW;
    localparam int SW  = PW + 1;
    localparam int EPW = 2 * DW;

    localparam logic signed [SW-1:0] LOC_MAX = (SW'(1) <<< (COORD_WIDTH - 1)) - SW'(1);
    localparam logic signed [SW-1:0] LOC_MIN = -LOC_MAX - SW'(1);
    localparam logic signed [SW-1:0] HALF_LSB = SW'(1) <<< 29;

    // Configuration registers.
    logic signed [COORD_WIDTH-1:0] r_pos_x;
    logic signed [COORD_WIDTH-1:0] r_pos_y;
    logic [ANGLE_WIDTH-1:0]        r_angle;
    logic [VCOUNT_W-1:0]           r_vcount;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x  <= '0;
            r_pos_y  <= '0;
            r_angle  <= '0;
            r_vcount <= VCOUNT_W'(3);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_POS_X:        r_pos_x  <= i_cfg_data[COORD_WIDTH-1:0];
                REG_POS_Y:        r_pos_y  <= i_cfg_data[COORD_WIDTH-1:0];
                REG_ORIENTATION:  r_angle  <= i_cfg_data[ANGLE_WIDTH-1:0];
                REG_VERTEX_COUNT: r_vcount <= i_cfg_data[VCOUNT_W-1:0];
                default:          r_pos_x  <= r_pos_x;
            endcase
        end
    end

    // Vertex count in use, clamped to the table.
    logic [KW-1:0] n_used;
    always_comb begin
        priority if (r_vcount < VCOUNT_W'(3)) begin
            n_used = KW'(3);
        end else if (32'(r_vcount) > MAX_VERTICES) begin
            n_used = KW'(MAX_VERTICES);
        end else begin
            n_used = KW'(r_vcount);
        end
    end

    // Vertex table.
    logic signed [COORD_WIDTH-1:0] mem_x [MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] mem_y [MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] r_rd_x;
    logic signed [COORD_WIDTH-1:0] r_rd_y;
    logic [KW-1:0]                 r_k;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_vertex && (32'(i_vertex_index) < MAX_VERTICES)) begin
            mem_x[AW'(i_vertex_index)] <= i_coord_x;
            mem_y[AW'(i_vertex_index)] <= i_coord_y;
        end
        r_rd_x <= mem_x[r_k[AW-1:0]];
        r_rd_y <= mem_y[r_k[AW-1:0]];
    end

    // Angle preparation: negate, fold the second and third quadrants.
    logic [31:0]            a32;
    logic [31:0]            neg_a;
    logic                   fold;
    logic signed [CS_W-1:0] z_init;

    always_comb begin
        a32    = {r_angle, {(32 - ANGLE_WIDTH){1'b0}}};
        neg_a  = 32'd0 - a32;
        fold   = neg_a[31] ^ neg_a[30];
        z_init = CS_W'($signed({neg_a[31] ^ fold, neg_a[30:0]}));
    end

    logic signed [CS_W-1:0] r_x;
    logic signed [CS_W-1:0] r_y;
    logic signed [CS_W-1:0] r_z;
    logic [STEP_W-1:0]      r_step;
    logic                   r_flip;
    logic signed [DW-1:0]   r_dx;
    logic signed [DW-1:0]   r_dy;
    logic signed [PW-1:0]   r_p0;
    logic signed [PW-1:0]   r_p1;
    logic signed [COORD_WIDTH-1:0] r_lx;
    logic signed [COORD_WIDTH-1:0] r_ly;

    logic signed [CS_W-1:0] xs;
    logic signed [CS_W-1:0] ys;
    assign xs = r_x >>> r_step;
    assign ys = r_y >>> r_step;

    function automatic logic signed [COORD_WIDTH-1:0] scale_sat(input logic signed [SW-1:0] s);
        logic signed [SW-1:0] t;
        t = (s + HALF_LSB) >>> 30;
        priority if (t > LOC_MAX) begin
            t = LOC_MAX;
        end else if (t < LOC_MIN) begin
            t = LOC_MIN;
        end
        return t[COORD_WIDTH-1:0];
    endfunction

    logic signed [SW-1:0] rot_sum;
    always_comb begin
        if (i_cmd.rot2) begin
            rot_sum = SW'(r_p0) - SW'(r_p1);
        end else begin
            rot_sum = SW'(r_p0) + SW'(r_p1);
        end
    end

    // Edge test registers: vertex positions relative to the local point.
    logic signed [DW-1:0]  r_v0x;
    logic signed [DW-1:0]  r_v0y;
    logic signed [DW-1:0]  r_prevx;
    logic signed [DW-1:0]  r_prevy;
    logic signed [DW-1:0]  r_curx;
    logic signed [DW-1:0]  r_cury;
    logic signed [EPW-1:0] r_e0;
    logic signed [EPW-1:0] r_e1;
    logic                  r_last;
    logic                  r_res;

    logic signed [DW-1:0]    rel_x;
    logic signed [DW-1:0]    rel_y;
    logic signed [EPW:0]     edge_cross;
    assign rel_x = DW'(r_rd_x) - DW'(r_lx);
    assign rel_y = DW'(r_rd_y) - DW'(r_ly);
    assign edge_cross = (EPW + 1)'(r_e0) - (EPW + 1)'(r_e1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_query) begin
            r_dx   <= DW'(i_coord_x) - DW'(r_pos_x);
            r_dy   <= DW'(i_coord_y) - DW'(r_pos_y);
            r_x    <= CORDIC_START;
            r_y    <= '0;
            r_z    <= z_init;
            r_flip <= fold;
            r_step <= '0;
            r_k    <= '0;
        end
        if (i_cmd.cordic_step) begin
            if (!r_z[CS_W-1]) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - atan_step(r_step);
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + atan_step(r_step);
            end
            r_step <= r_step + STEP_W'(1);
        end
        if (i_cmd.cordic_fix && r_flip) begin
            r_x <= -r_x;
            r_y <= -r_y;
        end
        if (i_cmd.rot1) begin
            r_p0 <= PW'(r_x) * PW'(r_dx);
            r_p1 <= PW'(r_y) * PW'(r_dy);
        end
        if (i_cmd.rot2) begin
            r_lx <= scale_sat(rot_sum);
            r_p0 <= PW'(r_y) * PW'(r_dx);
            r_p1 <= PW'(r_x) * PW'(r_dy);
        end
        if (i_cmd.rot3) begin
            r_ly <= scale_sat(rot_sum);
            r_k  <= KW'(1);
        end
        if (i_cmd.v0_cap) begin
            r_v0x   <= rel_x;
            r_v0y   <= rel_y;
            r_prevx <= rel_x;
            r_prevy <= rel_y;
        end
        if (i_cmd.load_cur) begin
            if (r_k == n_used) begin
                r_curx <= r_v0x;
                r_cury <= r_v0y;
            end else begin
                r_curx <= rel_x;
                r_cury <= rel_y;
            end
        end
        if (i_cmd.edge_mul) begin
            r_e0    <= EPW'(r_prevx) * EPW'(r_cury);
            r_e1    <= EPW'(r_prevy) * EPW'(r_curx);
            r_prevx <= r_curx;
            r_prevy <= r_cury;
            r_last  <= (r_k == n_used);
            r_k     <= r_k + KW'(1);
        end
        if (i_cmd.set_result) begin
            r_res <= i_cmd.result_val;
        end
    end

    // Output register.
    logic r_out_valid;
    logic r_out_inside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_inside <= r_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_inside_res = r_out_inside;

    assign o_stat.cordic_last = (r_step == STEP_W'(CORDIC_STEPS - 1));
    assign o_stat.edge_pos    = !edge_cross[EPW] && (edge_cross != '0);
    assign o_stat.edge_last   = r_last;
    assign o_stat.out_busy    = r_out_valid && i_out_stall;

endmodule

FILE: hw/rtl/point_in_posed_convex_polygon_unit.sv
`timescale 1ns / 1ps
// Point-in-convex-polygon test for a posed body.
// Input channel (i_in_valid / o_in_stall): a load request writes one vertex, in
// body-local Q16.16 coordinates, into table slot i_vertex_index; loads may follow
// back to back, and no result is produced. A query request carries a world point,
// which is moved into the body frame (position subtracted, rotated by minus the
// orientation) and tested against the edges of the counter-clockwise polygon in
// turn, stopping at the first edge that fails. Each query gives one result on the
// output channel (o_out_valid / i_out_stall): o_inside_res is 1 only if the point
// lies strictly inside; points on an edge count as outside.
// A query passes through the sixteen steps of the rotation unit, then sign fix,
// rotation and first-vertex set-up; each edge then takes a vertex fetch, the two
// cross-product multiplications and a sign check, and the result is then loaded
// into the output register. o_in_stall stays high while a query is worked on, so
// no new request is taken before the last query has reached the output register.
// A stalled receiver holds a result in the output register; a finished query
// then waits, input still stalled, until it has been taken. Configuration writes
// are always accepted and should be made while idle. Reset clears control and the
// configuration registers (vertex count three), not the table.

module point_in_posed_convex_polygon_unit
    import pipcp_pkg::*;
#(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_WIDTH  = 32,
    parameter int ANGLE_WIDTH  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_command,
    input  logic [VINDEX_W-1:0]           i_vertex_index,
    input  logic signed [COORD_WIDTH-1:0] i_coord_x,
    input  logic signed [COORD_WIDTH-1:0] i_coord_y,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_inside_res,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [((COORD_WIDTH > ANGLE_WIDTH) ? COORD_WIDTH : ANGLE_WIDTH)-1:0] i_cfg_data
);

    localparam int CFG_W = (COORD_WIDTH > ANGLE_WIDTH) ? COORD_WIDTH : ANGLE_WIDTH;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // The register file takes a write in every cycle.
    assign o_cfg_ready = 1'b1;

    pipcp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    pipcp_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_WIDTH  (COORD_WIDTH),
        .ANGLE_WIDTH  (ANGLE_WIDTH),
        .CFG_W        (CFG_W)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_vertex_index (i_vertex_index),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_inside_res   (o_inside_res)
    );

    // An accepted query occupies the block in the following cycle.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_command == CMD_QUERY)) |=> o_in_stall)
        else $error("query accepted but block did not go busy");

    // A load request never makes the block busy.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_command == CMD_LOAD)) |=> !o_in_stall)
        else $error("vertex load stalled the input");

    // A new result is only produced at the end of a query.
    a_result_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a query in progress");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import pipcp_pkg::*;

    // Holds its own copy of the vertex table and of the pose registers, works
    // out the expected inside flag for every accepted query and checks the
    // results in order.
    class containment_board;
        longint     vert_x [16];
        longint     vert_y [16];
        int         pose_x;
        int         pose_y;
        bit [15:0]  heading;
        bit [4:0]   nvert;
        bit         expected_inside [$];
        bit         failed;

        function new();
            pose_x  = 0;
            pose_y  = 0;
            heading = 0;
            nvert   = 5'd3;
            failed  = 0;
            foreach (vert_x[i]) begin
                vert_x[i] = 0;
                vert_y[i] = 0;
            end
        endfunction

        function void write_reg(bit [1:0] idx, bit [31:0] data);
            case (idx)
                REG_POS_X:        pose_x  = data;
                REG_POS_Y:        pose_y  = data;
                REG_ORIENTATION:  heading = data[15:0];
                REG_VERTEX_COUNT: nvert   = data[4:0];
                default: ;
            endcase
        endfunction

        // Cosine and sine of minus the heading, Q1.30, by sixteen rotation steps.
        function void neg_heading_trig(output longint c, output longint s);
            longint    atan_lut [16] = '{
                64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};
            bit [31:0] n;
            bit        flip;
            int        zi;
            longint    x, y, z, xs, ys;
            n    = 32'd0 - {heading, 16'd0};
            flip = (n[31:30] == 2'b01) || (n[31:30] == 2'b10);
            if (flip) n = n + 32'h8000_0000;
            zi = n;
            z  = zi;
            x  = 652032874;
            y  = 0;
            for (int i = 0; i < 16; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x = x - ys; y = y + xs; z = z - atan_lut[i];
                end else begin
                    x = x + ys; y = y - xs; z = z + atan_lut[i];
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function longint round_sat(logic signed [127:0] t);
            logic signed [127:0] r;
            r = (t + 128'sd536870912) >>> 30;
            if (r > 128'sd2147483647) return 64'sd2147483647;
            if (r < -128'sd2147483648) return -64'sd2147483648;
            return r[63:0];
        endfunction

        function bit inside_of(int qx, int qy);
            longint              c, s, lx, ly;
            logic signed [127:0] cw, sw, dxw, dyw, axw, ayw, bxw, byw, turn;
            int                  n, j;
            neg_heading_trig(c, s);
            cw  = c;
            sw  = s;
            dxw = longint'(qx) - longint'(pose_x);
            dyw = longint'(qy) - longint'(pose_y);
            lx  = round_sat(cw * dxw - sw * dyw);
            ly  = round_sat(sw * dxw + cw * dyw);
            n = nvert;
            if (n < 3) n = 3;
            if (n > 16) n = 16;
            for (int i = 0; i < n; i++) begin
                j   = (i + 1 == n) ? 0 : i + 1;
                axw = vert_x[i] - lx;
                ayw = vert_y[i] - ly;
                bxw = vert_x[j] - lx;
                byw = vert_y[j] - ly;
                turn = axw * byw - ayw * bxw;
                if (!(turn > 0)) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_request(bit cmd, bit [3:0] idx, int x, int y);
            if (cmd == CMD_LOAD) begin
                vert_x[idx] = x;
                vert_y[idx] = y;
            end else begin
                expected_inside.push_back(inside_of(x, y));
            end
        endfunction

        function void check_result(bit got);
            bit want;
            if (expected_inside.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d", $time, got);
                failed = 1;
                return;
            end
            want = expected_inside.pop_front();
            if (want !== got) begin
                $display("%0t: inside_res mismatch, expected %0d, actual %0d",
                         $time, want, got);
                failed = 1;
            end
        endfunction

        function int pending();
            return expected_inside.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_command;
    logic [VINDEX_W-1:0]  i_vertex_index;
    logic signed [31:0]   i_coord_x;
    logic signed [31:0]   i_coord_y;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_inside_res;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [31:0]          i_cfg_data;

    point_in_posed_convex_polygon_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_vertex_index (i_vertex_index),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_inside_res   (o_inside_res),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    containment_board board = new();

    // When calm is set, neither side inserts idle cycles.
    bit     calm;
    int     sent;
    int     quiet_cycles;
    real    poly_r;
    int     poly_n;

    localparam int  WATCHDOG_LIMIT = 5000;
    localparam int  SETTLE_CYCLES  = 100;
    localparam real TWO_PI         = 6.283185307179586;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Every accepted result is checked at the edge that accepts it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_result(o_inside_res);
    end

    // The watchdog counts cycles in which no channel moves a request.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // The receiver holds off for a random number of cycles before each result.
    initial begin
        int k;
        i_out_stall = 1'b0;
        forever begin
            k = calm ? 0 : $urandom_range(0, 11);
            repeat (k) begin
                @(negedge i_clk);
                i_out_stall = 1'b1;
            end
            @(negedge i_clk);
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    // One request on the input channel, after a random gap.
    task automatic send_req(bit cmd, bit [3:0] idx, int x, int y);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid     = 1'b1;
        i_command      = cmd;
        i_vertex_index = idx;
        i_coord_x      = x;
        i_coord_y      = y;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        board.note_request(cmd, idx, x, y);
        sent++;
    endtask

    // Waits until every expected result is in, then lets the block settle.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(bit [1:0] idx, bit [31:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        board.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Turns a body-local point into world coordinates for the current pose.
    function automatic void to_world(real lx, real ly, output int wx, output int wy);
        real th;
        th = TWO_PI * board.heading / 65536.0;
        wx = board.pose_x + $rtoi(lx * $cos(th) - ly * $sin(th));
        wy = board.pose_y + $rtoi(lx * $sin(th) + ly * $cos(th));
    endfunction

    // Loads a regular counter-clockwise polygon, or a collinear one when flat is set.
    task automatic load_polygon(int n, bit flat);
        real ph, a;
        poly_r = $itor($urandom_range(1, 4096)) * 65536.0;
        ph     = TWO_PI * $urandom_range(0, 999) / 1000.0;
        for (int k = 0; k < n; k++) begin
            a = ph + TWO_PI * k / n;
            if (flat)
                send_req(CMD_LOAD, 4'(k), $rtoi(poly_r * $cos(ph) * k / n),
                         $rtoi(poly_r * $sin(ph) * k / n));
            else
                send_req(CMD_LOAD, 4'(k), $rtoi(poly_r * $cos(a)), $rtoi(poly_r * $sin(a)));
        end
    endtask

    task automatic random_query();
        int  wx, wy, k;
        real lx, ly;
        if ($urandom_range(0, 99) < 15) begin
            send_req(CMD_QUERY, 4'($urandom), $urandom, $urandom);
        end else if ($urandom_range(0, 99) < 8) begin
            // A point on a vertex or halfway along an edge of the local polygon.
            k = $urandom_range(0, poly_n - 1);
            lx = board.vert_x[k];
            ly = board.vert_y[k];
            if ($urandom_range(0, 1)) begin
                lx = (lx + board.vert_x[(k + 1) % poly_n]) / 2.0;
                ly = (ly + board.vert_y[(k + 1) % poly_n]) / 2.0;
            end
            to_world(lx, ly, wx, wy);
            send_req(CMD_QUERY, 4'($urandom), wx, wy);
        end else begin
            lx = poly_r * ($urandom_range(0, 2600) - 1300) / 1000.0;
            ly = poly_r * ($urandom_range(0, 2600) - 1300) / 1000.0;
            to_world(lx, ly, wx, wy);
            send_req(CMD_QUERY, 4'($urandom), wx, wy);
        end
    endtask

    initial begin
        bit [31:0] cnt_data;
        int        eff;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_command      = CMD_LOAD;
        i_vertex_index = '0;
        i_coord_x      = '0;
        i_coord_y      = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = REG_POS_X;
        i_cfg_data     = '0;
        calm           = 1'b0;
        sent           = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part on the reset pose: a triangle in slots zero to two and
        // random contents in every other slot, so no unwritten slot is read.
        send_req(CMD_LOAD, 0, -32'sh80000, -32'sh80000);
        send_req(CMD_LOAD, 1, 32'sh80000, -32'sh80000);
        send_req(CMD_LOAD, 2, 0, 32'sh80000);
        for (int k = 3; k < 16; k++) send_req(CMD_LOAD, 4'(k), $urandom, $urandom);
        send_req(CMD_QUERY, 0, 0, 0);
        send_req(CMD_QUERY, 0, 0, -32'sh80000);
        send_req(CMD_QUERY, 0, -32'sh80000, -32'sh80000);
        send_req(CMD_QUERY, 0, 32'sh7fffffff, 32'sh7fffffff);
        send_req(CMD_QUERY, 0, 32'sh80000000, 32'sh80000000);
        send_req(CMD_QUERY, 0, 32'sh7fffffff, 32'sh80000000);
        // A repeated vertex makes the polygon degenerate.
        send_req(CMD_LOAD, 2, -32'sh80000, -32'sh80000);
        send_req(CMD_QUERY, 0, 0, -32'sh10000);
        drain();

        for (int phase = 0; sent < 1550; phase++) begin
            calm = ($urandom_range(0, 3) == 0);
            case (phase)
                0: begin
                    write_reg(REG_POS_X, 32'h8000_0000);
                    write_reg(REG_POS_Y, 32'h7fff_ffff);
                    write_reg(REG_ORIENTATION, 32'h0000_ffff);
                    cnt_data = 32'h0000_001f;
                end
                1: begin
                    write_reg(REG_POS_X, 0);
                    write_reg(REG_POS_Y, 0);
                    write_reg(REG_ORIENTATION, 32'h0000_8000);
                    cnt_data = 32'h0000_0002;
                end
                2: begin
                    write_reg(REG_ORIENTATION, 32'h0000_4000);
                    cnt_data = 32'h0000_0010;
                end
                3: begin
                    write_reg(REG_ORIENTATION, 32'hffff_0000);
                    cnt_data = 32'hffff_ffe0;
                end
                default: begin
                    write_reg(REG_POS_X, $urandom_range(0, 3) == 0 ? $urandom
                                         : $urandom_range(0, 32'h0800_0000) - 32'h0400_0000);
                    write_reg(REG_POS_Y, $urandom_range(0, 3) == 0 ? $urandom
                                         : $urandom_range(0, 32'h0800_0000) - 32'h0400_0000);
                    write_reg(REG_ORIENTATION, $urandom);
                    cnt_data = {27'($urandom_range(0, 32'h07ff_ffff)), 5'(
                                $urandom_range(0, 7) == 0 ? $urandom_range(0, 31)
                                                          : $urandom_range(3, 16))};
                end
            endcase
            write_reg(REG_VERTEX_COUNT, cnt_data);
            eff = cnt_data[4:0];
            if (eff < 3) eff = 3;
            if (eff > 16) eff = 16;
            poly_n = eff;
            load_polygon(eff, phase == 5 || $urandom_range(0, 19) == 0);
            for (int q = 0; q < 60; q++) begin
                if (q == 30 && phase % 4 == 1) begin
                    // The sender pauses until the block has nothing outstanding.
                    @(negedge i_clk);
                    i_in_valid = 1'b0;
                    while (board.pending() != 0) @(posedge i_clk);
                end
                if (eff < 16 && $urandom_range(0, 9) == 0)
                    send_req(CMD_LOAD, 4'($urandom_range(eff, 15)), $urandom, $urandom);
                else
                    random_query();
            end
            drain();
        end

        drain();
        if (!board.failed && board.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/pipcp_pkg.sv
hw/rtl/pipcp_ctrl.sv
hw/rtl/pipcp_dp.sv
hw/rtl/point_in_posed_convex_polygon_unit.sv
tb/sv/tb.sv
